@@ design/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_insert.
package spq_pkg;

  localparam int VALUE_W     = 32;
  localparam int LEVEL_W     = 3;
  localparam int STATUS_W    = 3;
  localparam int LEVEL_COUNT = 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_LEVEL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic                      ins;
    logic                      rot;
    logic signed [VALUE_W-1:0] ins_value;
    logic [LEVEL_W-1:0]        ins_level;
    logic signed [VALUE_W-1:0] head_value;
    logic [LEVEL_W-1:0]        head_level;
  } cell_cmd_t;

  // Position of one cell relative to the fill count.
  typedef struct packed {
    logic occ;      // cell holds an entry
    logic at_fill;  // first free cell
    logic at_last;  // last occupied cell
  } cell_pos_t;

endpackage

@@ design/sorted_priority_queue_insert.sv @@
// Top level of the sorted priority queue: control, fill count, result register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: an insert of
//   in_value at priority in_level (0..5, lower served first), or a read.
//   An insert returns one result: inserted, full (dropped) or bad
//   priority (levels 6 and 7). Equal priorities stay in arrival order.
//   A read returns one result per stored entry, head first, entries kept,
//   with out_last on the final one; an empty queue gives one empty status.
//   A read first enters the read state, then emits the head entry whenever
//   the result register is free (an empty store answers straight from idle,
//   as an insert does); the entries rotate through a chain of DEPTH cells
//   and the head cell feeds the result register.
//   Results sit in an output register; while out_stall holds, the result
//   and the read stay frozen and no new request is taken. in_stall is high
//   during a read and whenever a stalled result blocks the register.
//   Reset (rst_n low, synchronous) empties the queue and drops any result.
module sorted_priority_queue_insert #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  input  logic [spq_pkg::LEVEL_W-1:0]         in_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [spq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_entry_value,
  output logic [spq_pkg::LEVEL_W-1:0]         out_entry_level,
  output logic                                out_last
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                 state_r, state_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [FILL_W-1:0]    cnt_r, cnt_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [spq_pkg::STATUS_W-1:0]        status_r, status_nxt;
  logic signed [spq_pkg::VALUE_W-1:0]  evalue_r, evalue_nxt;
  logic [spq_pkg::LEVEL_W-1:0]         elevel_r, elevel_nxt;
  logic                                last_r, last_nxt;

  logic                 out_free;
  logic                 in_acc;
  spq_pkg::cell_cmd_t   cmd;

  logic                                cell_gt    [DEPTH];
  logic signed [spq_pkg::VALUE_W-1:0]  cell_value [DEPTH];
  logic [spq_pkg::LEVEL_W-1:0]         cell_level [DEPTH];

  // Result register may load when empty or being taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_entry_value = evalue_r;
  assign out_entry_level = elevel_r;
  assign out_last        = last_r;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    evalue_nxt    = evalue_r;
    elevel_nxt    = elevel_r;
    last_nxt      = last_r;

    cmd.ins        = 1'b0;
    cmd.rot        = 1'b0;
    cmd.ins_value  = in_value;
    cmd.ins_level  = in_level;
    cmd.head_value = cell_value[0];
    cmd.head_level = cell_level[0];

    // drop a result that is taken this cycle
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == spq_pkg::OP_INSERT) begin
            out_valid_nxt = 1'b1;
            evalue_nxt    = '0;
            elevel_nxt    = '0;
            last_nxt      = 1'b1;
            if (in_level >= spq_pkg::LEVEL_W'(spq_pkg::LEVEL_COUNT)) begin
              status_nxt = spq_pkg::ST_BAD_LEVEL;
            end else if (fill_r == FILL_W'(DEPTH)) begin
              status_nxt = spq_pkg::ST_FULL;
            end else begin
              status_nxt = spq_pkg::ST_INSERTED;
              cmd.ins    = 1'b1;
              fill_nxt   = fill_r + FILL_W'(1);
            end
          end else if (fill_r == '0) begin
            out_valid_nxt = 1'b1;
            status_nxt    = spq_pkg::ST_EMPTY;
            evalue_nxt    = '0;
            elevel_nxt    = '0;
            last_nxt      = 1'b1;
          end else begin
            state_nxt = S_READ;
            cnt_nxt   = '0;
          end
        end
      end
      S_READ: begin
        // emit the head, rotate the occupied cells one step left
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = spq_pkg::ST_ENTRY;
          evalue_nxt    = cell_value[0];
          elevel_nxt    = cell_level[0];
          last_nxt      = (cnt_r == fill_r - FILL_W'(1));
          cmd.rot       = 1'b1;
          cnt_nxt       = cnt_r + FILL_W'(1);
          if (cnt_r == fill_r - FILL_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    evalue_r <= evalue_nxt;
    elevel_r <= elevel_nxt;
    last_r   <= last_nxt;
  end

  // Chain of cells, head at index 0.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::cell_pos_t                 pos;
    logic                               l_gt;
    logic signed [spq_pkg::VALUE_W-1:0] l_value;
    logic [spq_pkg::LEVEL_W-1:0]        l_level;
    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic [spq_pkg::LEVEL_W-1:0]        r_level;

    assign pos.occ     = FILL_W'(i) < fill_r;
    assign pos.at_fill = FILL_W'(i) == fill_r;
    assign pos.at_last = FILL_W'(i) == fill_r - FILL_W'(1);

    if (i == 0) begin : g_head
      assign l_gt    = 1'b0;
      assign l_value = '0;
      assign l_level = '0;
    end else begin : g_left
      assign l_gt    = cell_gt[i-1];
      assign l_value = cell_value[i-1];
      assign l_level = cell_level[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      // the tail cell is always the last occupied one when occupied
      assign r_value = cell_value[0];
      assign r_level = cell_level[0];
    end else begin : g_right
      assign r_value = cell_value[i+1];
      assign r_level = cell_level[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .left_gt     (l_gt),
      .left_value  (l_value),
      .left_level  (l_level),
      .right_value (r_value),
      .right_level (r_level),
      .gt          (cell_gt[i]),
      .value       (cell_value[i]),
      .level       (cell_level[i])
    );
  end

endmodule

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts right on insert,
// rotates left on read. Depends on spq_pkg.
module spq_cell (
  input  logic                               clk,
  input  spq_pkg::cell_cmd_t                 cmd,
  input  spq_pkg::cell_pos_t                 pos,
  input  logic                               left_gt,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  logic [spq_pkg::LEVEL_W-1:0]        left_level,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
  input  logic [spq_pkg::LEVEL_W-1:0]        right_level,
  output logic                               gt,
  output logic signed [spq_pkg::VALUE_W-1:0] value,
  output logic [spq_pkg::LEVEL_W-1:0]        level
);

  logic signed [spq_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [spq_pkg::LEVEL_W-1:0]        level_r, level_nxt;

  // Stored entry ranks strictly after the new one.
  assign gt    = pos.occ && (level_r > cmd.ins_level);
  assign value = value_r;
  assign level = level_r;

  always_comb begin
    value_nxt = value_r;
    level_nxt = level_r;
    if (cmd.ins && (gt || pos.at_fill)) begin
      // take left neighbor when it moves too, else the new entry lands here
      if (left_gt) begin
        value_nxt = left_value;
        level_nxt = left_level;
      end else begin
        value_nxt = cmd.ins_value;
        level_nxt = cmd.ins_level;
      end
    end else if (cmd.rot && pos.occ) begin
      if (pos.at_last) begin
        value_nxt = cmd.head_value;
        level_nxt = cmd.head_level;
      end else begin
        value_nxt = right_value;
        level_nxt = right_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    level_r <= level_nxt;
  end

endmodule
